// File: src/rmq_pkg.sv
// Shared constants and types for the rotation matrix to quaternion block.
`timescale 1ns / 1ps
package rmq_pkg;

  localparam int DATA_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF  = 14;
  localparam int THR_W          = 15;
  localparam int CFG_DATA_W     = 32;
  localparam int CFG_ADDR_W     = 3;
  localparam int NUM_LANES      = 3;

  localparam logic [THR_W-1:0] THR_RESET = 15'd2;

  // register index of trace_threshold
  localparam logic REG_TRACE_THRESHOLD = 1'b0;

  typedef enum logic [1:0] {
    PATH_TRACE,
    PATH_X,
    PATH_Y,
    PATH_Z
  } path_t;

endpackage

// File: src/rmq_if.sv
// Handshake channels for matrix input and quaternion output.
`timescale 1ns / 1ps
interface rmq_in_if #(parameter int DATA_WIDTH = 16) ();
  logic valid;
  logic ready;
  logic signed [DATA_WIDTH-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;

  modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  input ready);
  modport sink (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                output ready);
endinterface

interface rmq_out_if #(parameter int DATA_WIDTH = 16) ();
  logic valid;
  logic ready;
  logic signed [DATA_WIDTH-1:0] qw, qx, qy, qz;
  logic degenerate;

  modport source (output valid, qw, qx, qy, qz, degenerate, input ready);
  modport sink (input valid, qw, qx, qy, qz, degenerate, output ready);
endinterface

// File: src/rmq_sqrt_cell.sv
// One digit cell of the pipelined integer square root.
`timescale 1ns / 1ps
module rmq_sqrt_cell #(
  parameter int RN = 16,
  parameter int PW = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            v_in,
  input  logic [2*RN-1:0] arg_in,
  input  logic [RN+1:0]   rem_in,
  input  logic [RN-1:0]   root_in,
  input  logic [PW-1:0]   pay_in,
  output logic            v_out,
  output logic [2*RN-1:0] arg_out,
  output logic [RN+1:0]   rem_out,
  output logic [RN-1:0]   root_out,
  output logic [PW-1:0]   pay_out
);

  logic [RN+3:0] rem_sh;
  logic [RN+3:0] trial;
  logic          take;
  logic          v_r;
  logic [2*RN-1:0] arg_r;
  logic [RN+1:0] rem_r, rem_nxt;
  logic [RN-1:0] root_r, root_nxt;
  logic [PW-1:0] pay_r;

  always_comb begin
    rem_sh = {rem_in, arg_in[2*RN-1 -: 2]};
    trial  = (RN+4)'({root_in, 2'b01});
    take   = (rem_sh >= trial);
    if (take) begin
      rem_nxt  = (RN+2)'(rem_sh - trial);
      root_nxt = {root_in[RN-2:0], 1'b1};
    end else begin
      rem_nxt  = rem_sh[RN+1:0];
      root_nxt = {root_in[RN-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      arg_r  <= {arg_in[2*RN-3:0], 2'b00};
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      pay_r  <= pay_in;
    end
  end

  assign v_out    = v_r;
  assign arg_out  = arg_r;
  assign rem_out  = rem_r;
  assign root_out = root_r;
  assign pay_out  = pay_r;

endmodule

// File: src/rmq_div_cell.sv
// One quotient-bit cell of the pipelined restoring dividers, all lanes.
`timescale 1ns / 1ps
module rmq_div_cell #(
  parameter int DW = 17,
  parameter int NW = 31,
  parameter int PW = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                v_in,
  input  logic [DW-1:0]                       d_in,
  input  logic [rmq_pkg::NUM_LANES*NW-1:0]     n_in,
  input  logic [rmq_pkg::NUM_LANES*(DW+1)-1:0] rem_in,
  input  logic [rmq_pkg::NUM_LANES*NW-1:0]     q_in,
  input  logic [PW-1:0]                       pay_in,
  output logic                                v_out,
  output logic [DW-1:0]                       d_out,
  output logic [rmq_pkg::NUM_LANES*NW-1:0]     n_out,
  output logic [rmq_pkg::NUM_LANES*(DW+1)-1:0] rem_out,
  output logic [rmq_pkg::NUM_LANES*NW-1:0]     q_out,
  output logic [PW-1:0]                       pay_out
);
  import rmq_pkg::*;

  logic                         v_r;
  logic [DW-1:0]                d_r;
  logic [NUM_LANES*NW-1:0]      n_r, n_nxt;
  logic [NUM_LANES*(DW+1)-1:0]  rem_r, rem_nxt;
  logic [NUM_LANES*NW-1:0]      q_r, q_nxt;
  logic [PW-1:0]                pay_r;

  always_comb begin
    logic [DW+1:0] rs;
    for (int l = 0; l < NUM_LANES; l++) begin
      rs = {rem_in[l*(DW+1) +: DW+1], n_in[l*NW + NW-1]};
      n_nxt[l*NW +: NW] = {n_in[l*NW +: NW-1], 1'b0};
      if (rs >= (DW+2)'(d_in)) begin
        rem_nxt[l*(DW+1) +: DW+1] = (DW+1)'(rs - (DW+2)'(d_in));
        q_nxt[l*NW +: NW] = {q_in[l*NW +: NW-1], 1'b1};
      end else begin
        rem_nxt[l*(DW+1) +: DW+1] = rs[DW:0];
        q_nxt[l*NW +: NW] = {q_in[l*NW +: NW-1], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r   <= d_in;
      n_r   <= n_nxt;
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
      pay_r <= pay_in;
    end
  end

  assign v_out   = v_r;
  assign d_out   = d_r;
  assign n_out   = n_r;
  assign rem_out = rem_r;
  assign q_out   = q_r;
  assign pay_out = pay_r;

endmodule

// File: src/rotation_matrix_to_quaternion.sv
// Rotation matrix to unit quaternion: path select, root cell chain, divider cell chain.
//
//  channel | direction | handshake          | payload
//  in_ch   | in        | valid/ready        | m00..m22, DATA_WIDTH signed each
//  out_ch  | out       | valid/ready        | qw qx qy qz signed, degenerate
//  cfg_*   | in        | APB psel/penable   | trace_threshold at byte 0
//
// One matrix per cycle enters while in_ch.ready is high. A matrix passes the input
// register, the root chain (one cell per root bit), the divider chain (one
// cell per quotient bit) and the output register. A stalled output register freezes the whole chain.
// Reset clears all valid bits and sets trace_threshold to 2.
`timescale 1ns / 1ps
module rotation_matrix_to_quaternion #(
  parameter int DATA_WIDTH = rmq_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = rmq_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  rmq_in_if.sink                          in_ch,
  rmq_out_if.source                       out_ch,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [rmq_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [rmq_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [rmq_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                            cfg_pready
);
  import rmq_pkg::*;

  localparam int UW  = DATA_WIDTH + 2;
  localparam int SW  = UW + FRAC_BITS;
  localparam int RN  = (SW + 1) / 2;
  localparam int NMW = DATA_WIDTH + 1;
  localparam int NW  = NMW + FRAC_BITS;
  localparam int DVW = RN + 1;
  localparam int CW  = (UW > THR_W + 1) ? UW : THR_W + 1;
  localparam int SPW = 2 + NUM_LANES * (NMW + 2);
  localparam int DPW = 2 + (RN - 1) + 1 + 2 * NUM_LANES;
  localparam logic [NW-1:0] QMAX = NW'((64'd1 << (DATA_WIDTH - 1)) - 64'd1);
  localparam logic [NW-1:0] QLIM = NW'(64'd1 << (DATA_WIDTH - 1));
  localparam logic signed [DATA_WIDTH-1:0] OMAX = QMAX[DATA_WIDTH-1:0];
  localparam logic signed [DATA_WIDTH-1:0] OMIN = QLIM[DATA_WIDTH-1:0];
  localparam logic signed [UW-1:0] ONE = UW'(64'd1 << FRAC_BITS);

  // ---------------- configuration ----------------
  logic [THR_W-1:0] thr_r;
  logic             cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_wr && cfg_paddr[2] == REG_TRACE_THRESHOLD) begin
      thr_r <= cfg_pwdata[THR_W-1:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_TRACE_THRESHOLD) ?
                      CFG_DATA_W'(thr_r) : '0;

  // ---------------- flow control ----------------
  logic out_v_r;
  logic en;

  assign en = !out_v_r || out_ch.ready;
  assign in_ch.ready = en;

  // ---------------- path select ----------------
  logic signed [UW-1:0]  a00, a01, a02, a10, a11, a12, a20, a21, a22;
  logic signed [UW-1:0]  tr, arg;
  logic signed [NMW-1:0] num [NUM_LANES];
  logic [NMW-1:0]        mag [NUM_LANES];
  logic [NUM_LANES-1:0]  neg, zro;
  path_t                 path;

  always_comb begin
    a00 = UW'(in_ch.m00); a01 = UW'(in_ch.m01); a02 = UW'(in_ch.m02);
    a10 = UW'(in_ch.m10); a11 = UW'(in_ch.m11); a12 = UW'(in_ch.m12);
    a20 = UW'(in_ch.m20); a21 = UW'(in_ch.m21); a22 = UW'(in_ch.m22);
    tr = a00 + a11 + a22 + ONE;
    if (CW'(tr) > $signed(CW'({1'b0, thr_r}))) begin
      path = PATH_TRACE;
    end else if (a00 > a11 && a00 > a22) begin
      path = PATH_X;
    end else if (a11 > a22) begin
      path = PATH_Y;
    end else begin
      path = PATH_Z;
    end
    case (path)
      PATH_TRACE: begin
        arg = tr;
        num[0] = NMW'(a21 - a12); num[1] = NMW'(a02 - a20); num[2] = NMW'(a10 - a01);
      end
      PATH_X: begin
        arg = ONE + a00 - a11 - a22;
        num[0] = NMW'(a21 - a12); num[1] = NMW'(a01 + a10); num[2] = NMW'(a02 + a20);
      end
      PATH_Y: begin
        arg = ONE + a11 - a00 - a22;
        num[0] = NMW'(a02 - a20); num[1] = NMW'(a01 + a10); num[2] = NMW'(a12 + a21);
      end
      default: begin
        arg = ONE + a22 - a00 - a11;
        num[0] = NMW'(a10 - a01); num[1] = NMW'(a02 + a20); num[2] = NMW'(a12 + a21);
      end
    endcase
    // clamp a negative root argument to zero
    if (arg < 0) begin
      arg = '0;
    end
    for (int l = 0; l < NUM_LANES; l++) begin
      neg[l] = num[l][NMW-1];
      zro[l] = (num[l] == '0);
      mag[l] = neg[l] ? NMW'(-num[l]) : NMW'(num[l]);
    end
  end

  // ---------------- root chain ----------------
  logic            sq_v    [RN+1];
  logic [2*RN-1:0] sq_arg  [RN+1];
  logic [RN+1:0]   sq_rem  [RN+1];
  logic [RN-1:0]   sq_root [RN+1];
  logic [SPW-1:0]  sq_pay  [RN+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v[0] <= 1'b0;
    end else if (en) begin
      sq_v[0] <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_arg[0]  <= (2*RN)'({arg, {FRAC_BITS{1'b0}}});
      sq_rem[0]  <= '0;
      sq_root[0] <= '0;
      sq_pay[0]  <= {path, zro, neg, mag[2], mag[1], mag[0]};
    end
  end

  for (genvar i = 0; i < RN; i++) begin : g_sq
    rmq_sqrt_cell #(.RN(RN), .PW(SPW)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .v_in(sq_v[i]), .arg_in(sq_arg[i]), .rem_in(sq_rem[i]),
      .root_in(sq_root[i]), .pay_in(sq_pay[i]),
      .v_out(sq_v[i+1]), .arg_out(sq_arg[i+1]), .rem_out(sq_rem[i+1]),
      .root_out(sq_root[i+1]), .pay_out(sq_pay[i+1])
    );
  end

  // ---------------- divider chain ----------------
  logic                          dv_v   [NW+1];
  logic [DVW-1:0]                dv_d   [NW+1];
  logic [NUM_LANES*NW-1:0]       dv_n   [NW+1];
  logic [NUM_LANES*(DVW+1)-1:0]  dv_rem [NW+1];
  logic [NUM_LANES*NW-1:0]       dv_q   [NW+1];
  logic [DPW-1:0]                dv_pay [NW+1];
  logic [RN-1:0]                 r_fin;
  logic [SPW-1:0]                sp;

  assign r_fin = sq_root[RN];
  assign sp    = sq_pay[RN];
  assign dv_v[0]   = sq_v[RN];
  assign dv_d[0]   = {r_fin, 1'b0};
  assign dv_rem[0] = '0;
  assign dv_q[0]   = '0;
  // path, own component r/2, degenerate, zero flags, sign flags
  assign dv_pay[0] = {sp[SPW-1 -: 2], r_fin[RN-1:1], (r_fin == '0),
                      sp[NUM_LANES*NMW +: 2*NUM_LANES]};

  for (genvar l = 0; l < NUM_LANES; l++) begin : g_num
    assign dv_n[0][l*NW +: NW] = {sp[l*NMW +: NMW], {FRAC_BITS{1'b0}}};
  end

  for (genvar i = 0; i < NW; i++) begin : g_dv
    rmq_div_cell #(.DW(DVW), .NW(NW), .PW(DPW)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .v_in(dv_v[i]), .d_in(dv_d[i]), .n_in(dv_n[i]), .rem_in(dv_rem[i]),
      .q_in(dv_q[i]), .pay_in(dv_pay[i]),
      .v_out(dv_v[i+1]), .d_out(dv_d[i+1]), .n_out(dv_n[i+1]),
      .rem_out(dv_rem[i+1]), .q_out(dv_q[i+1]), .pay_out(dv_pay[i+1])
    );
  end

  // ---------------- saturation and output register ----------------
  logic [DPW-1:0]               fp;
  path_t                        f_path;
  logic [RN-2:0]                f_own;
  logic                         f_deg;
  logic [NUM_LANES-1:0]         f_neg, f_zro;
  logic [NW-1:0]                f_q [NUM_LANES];
  logic signed [DATA_WIDTH-1:0] lane [NUM_LANES];
  logic signed [DATA_WIDTH-1:0] own;
  logic signed [DATA_WIDTH-1:0] qw_nxt, qx_nxt, qy_nxt, qz_nxt;
  logic signed [DATA_WIDTH-1:0] qw_r, qx_r, qy_r, qz_r;
  logic                         deg_r;

  always_comb begin
    fp     = dv_pay[NW];
    f_path = path_t'(fp[DPW-1 -: 2]);
    f_own  = fp[DPW-3 -: RN-1];
    f_deg  = fp[2*NUM_LANES];
    f_zro  = fp[NUM_LANES +: NUM_LANES];
    f_neg  = fp[0 +: NUM_LANES];
    own = (NW'(f_own) > QMAX) ? OMAX : DATA_WIDTH'(f_own);
    for (int l = 0; l < NUM_LANES; l++) begin
      f_q[l] = dv_q[NW][l*NW +: NW];
      if (f_zro[l]) begin
        lane[l] = '0;
      end else if (f_neg[l]) begin
        lane[l] = (f_q[l] >= QLIM) ? OMIN : -$signed(f_q[l][DATA_WIDTH-1:0]);
      end else begin
        lane[l] = (f_q[l] > QMAX) ? OMAX : $signed(f_q[l][DATA_WIDTH-1:0]);
      end
    end
    case (f_path)
      PATH_TRACE: begin
        qw_nxt = own; qx_nxt = lane[0]; qy_nxt = lane[1]; qz_nxt = lane[2];
      end
      PATH_X: begin
        qw_nxt = lane[0]; qx_nxt = own; qy_nxt = lane[1]; qz_nxt = lane[2];
      end
      PATH_Y: begin
        qw_nxt = lane[0]; qx_nxt = lane[1]; qy_nxt = own; qz_nxt = lane[2];
      end
      default: begin
        qw_nxt = lane[0]; qx_nxt = lane[1]; qy_nxt = lane[2]; qz_nxt = own;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= dv_v[NW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qw_r  <= qw_nxt;
      qx_r  <= qx_nxt;
      qy_r  <= qy_nxt;
      qz_r  <= qz_nxt;
      deg_r <= f_deg;
    end
  end

  assign out_ch.valid      = out_v_r;
  assign out_ch.qw         = qw_r;
  assign out_ch.qx         = qx_r;
  assign out_ch.qy         = qy_r;
  assign out_ch.qz         = qz_r;
  assign out_ch.degenerate = deg_r;

`ifndef SYNTHESIS
  // a degenerate result holds only zero or limit values
  a_deg_values: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && deg_r) |->
      ((qw_r == 0 || qw_r == OMAX || qw_r == OMIN) &&
       (qx_r == 0 || qx_r == OMAX || qx_r == OMIN) &&
       (qy_r == 0 || qy_r == OMAX || qy_r == OMIN) &&
       (qz_r == 0 || qz_r == OMAX || qz_r == OMIN)))
    else $error("degenerate result with non-limit value");

  // a stalled chain keeps its last cells
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> ($stable(dv_v[NW]) && $stable(sq_v[RN])))
    else $error("chain advanced during stall");

  // the chain comes out of reset empty
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> (!out_v_r && !dv_v[NW] && !sq_v[RN] && !sq_v[0]))
    else $error("valid bit survived reset");
`endif

endmodule
